// ===== design/bkv_pkg.sv =====
package bkv_pkg;

	// field widths
	localparam int unsigned CNT_W    = 6;
	localparam int unsigned NUM_W    = 64;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CLASS_W  = 2;
	localparam int unsigned MATCH_W  = 3;

	// parameter defaults
	localparam int unsigned FRAME_BYTES_DEF = 40;
	localparam int unsigned KEY_BYTES_DEF   = 16;

	// input opcodes
	localparam logic OP_BYTE     = 1'b0;
	localparam logic OP_LINE_ERR = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FORMAT    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_KEY_ERR   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE_ERR = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OTHER_KEY = 3'd4;

	// key classes
	localparam logic [CLASS_W-1:0] KC_OTHER = 2'd0;
	localparam logic [CLASS_W-1:0] KC_ODO   = 2'd1;
	localparam logic [CLASS_W-1:0] KC_Q4ODO = 2'd2;

	// characters
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// key match progress
	localparam logic [MATCH_W-1:0] MATCH_FAIL    = 3'd7;
	localparam logic [MATCH_W-1:0] ODO_LEN       = 3'd3;
	localparam logic [MATCH_W-1:0] Q4ODO_LEN     = 3'd6;

	typedef struct packed {
		logic               in_frame;
		logic [CNT_W-1:0]   stored_count;
		logic               comma_seen;
		logic [CNT_W-1:0]   key_count;
		logic [MATCH_W-1:0] odo_match;
		logic [MATCH_W-1:0] q4odo_match;
		logic [NUM_W-1:0]   accumulator;
		logic [CNT_W-1:0]   digit_count;
		logic               value_bad;
	} frame_state_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CLASS_W-1:0]  key_class;
		logic [CNT_W-1:0]    key_len;
		logic [NUM_W-1:0]    number;
	} frame_result_t;

	function automatic logic [7:0] odo_char(input logic [MATCH_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h6F; // o
			3'd1:    c = 8'h64; // d
			default: c = 8'h6F; // o
		endcase
		return c;
	endfunction

	function automatic logic [7:0] q4odo_char(input logic [MATCH_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h71; // q
			3'd1:    c = 8'h34; // 4
			3'd2:    c = 8'h5F; // _
			3'd3:    c = 8'h6F; // o
			3'd4:    c = 8'h64; // d
			default: c = 8'h6F; // o
		endcase
		return c;
	endfunction

	function automatic logic [MATCH_W-1:0] match_next(
		input logic [MATCH_W-1:0] prog,
		input logic [MATCH_W-1:0] len,
		input logic [7:0]         expect_c,
		input logic [7:0]         b
	);
		logic [MATCH_W-1:0] r;
		if (prog >= len || expect_c != b) begin
			r = MATCH_FAIL;
		end else begin
			r = prog + MATCH_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== design/bkv_in_if.sv =====
interface bkv_in_if import bkv_pkg::*; ;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// ===== design/bkv_out_if.sv =====
interface bkv_out_if import bkv_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [CLASS_W-1:0]  key_class;
	logic [CNT_W-1:0]    key_len;
	logic [NUM_W-1:0]    number;

	modport source (output valid, output status, output key_class, output key_len,
		output number, input ready);
	modport sink   (input valid, input status, input key_class, input key_len,
		input number, output ready);
endinterface

// ===== design/bkv_step.sv =====
module bkv_step import bkv_pkg::*; #(
	parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
	parameter int unsigned KEY_BYTES   = KEY_BYTES_DEF
) (
	input  frame_state_t  cur,
	input  logic          op,
	input  logic [7:0]    rx_byte,
	output frame_state_t  nxt,
	output logic          emit,
	output frame_result_t result
);

	localparam logic [CNT_W-1:0] STORE_MAX = CNT_W'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] KEY_MAX   = CNT_W'(KEY_BYTES);

	logic [NUM_W+3:0] acc_x10;
	logic [NUM_W+3:0] acc_next;
	logic             is_digit;

	// acc*10 + digit, overflow shows in the top nibble
	assign acc_x10  = ({4'b0, cur.accumulator} << 3) + ({4'b0, cur.accumulator} << 1);
	assign acc_next = acc_x10 + (NUM_W+4)'(rx_byte - CH_ZERO);
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

	always_comb begin
		nxt    = cur;
		emit   = 1'b0;
		result = '0;
		if (op == OP_LINE_ERR) begin
			nxt = '0;
		end else begin
			if (rx_byte == CH_LBRACK) begin
				nxt          = '0;
				nxt.in_frame = 1'b1;
			end
			if (nxt.in_frame) begin
				if (nxt.stored_count >= STORE_MAX) begin
					nxt = '0;
				end else begin
					nxt.stored_count = nxt.stored_count + CNT_W'(1);
					if (rx_byte == CH_RBRACK) begin
						emit = 1'b1;
						if (!nxt.comma_seen) begin
							result.status = ST_FORMAT;
						end else begin
							result.key_len = nxt.key_count;
							if (nxt.key_count == '0 || nxt.key_count >= KEY_MAX) begin
								result.status = ST_KEY_ERR;
							end else begin
								if (nxt.odo_match == ODO_LEN) begin
									result.key_class = KC_ODO;
								end else if (nxt.q4odo_match == Q4ODO_LEN) begin
									result.key_class = KC_Q4ODO;
								end
								if (result.key_class == KC_OTHER) begin
									result.status = ST_OTHER_KEY;
								end else if (nxt.digit_count == '0 || nxt.value_bad) begin
									result.status = ST_RANGE_ERR;
								end else begin
									result.status = ST_OK;
									result.number = nxt.accumulator;
								end
							end
						end
						nxt = '0;
					end else if (rx_byte != CH_LBRACK) begin
						if (!nxt.comma_seen) begin
							if (rx_byte == CH_COMMA) begin
								nxt.comma_seen = 1'b1;
							end else begin
								if (nxt.key_count != '1) begin
									nxt.key_count = nxt.key_count + CNT_W'(1);
								end
								nxt.odo_match = match_next(cur.odo_match, ODO_LEN,
									odo_char(cur.odo_match), rx_byte);
								nxt.q4odo_match = match_next(cur.q4odo_match, Q4ODO_LEN,
									q4odo_char(cur.q4odo_match), rx_byte);
							end
						end else begin
							if (nxt.digit_count != '1) begin
								nxt.digit_count = nxt.digit_count + CNT_W'(1);
							end
							if (!cur.value_bad) begin
								if (!is_digit || acc_next[NUM_W+3:NUM_W] != 4'd0) begin
									nxt.value_bad = 1'b1;
								end else begin
									nxt.accumulator = acc_next[NUM_W-1:0];
								end
							end
						end
					end
				end
			end
		end
	end

endmodule

// ===== design/bracket_key_value_frame_parser_core.sv =====
// Bracket key/value frame parser.
// rx (sink): one transfer per UART event; op selects a received byte or a
//   line error, which drops any open frame without a result.
// res (source): one transfer per closing ']' inside a frame, carrying
//   status, key class, key length and the parsed 64-bit decimal value.
// Frames look like "[key,value]"; '[' always restarts a frame, bytes outside
//   a frame are dropped, an overlong frame is dropped silently.
// Path: an item waits in the input register; when it retires, its result is
//   loaded into the output register, which drives res.valid until the
//   result transfer on res.ready.
// Throughput: one item per cycle when not stalled; the per-byte state update
//   (key match, accumulator times ten plus digit) is a single combinational pass.
// Stall: while a result waits in the output register, items that give no
//   result keep flowing; rx.ready drops only when the item in the input
//   register would give a result and the output register is held.
// Reset: arst_n clears the frame state and both valid flags; no frame is
//   open afterwards.
module bracket_key_value_frame_parser_core import bkv_pkg::*; #(
	parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
	parameter int unsigned KEY_BYTES   = KEY_BYTES_DEF
) (
	input logic     clk,
	input logic     arst_n,
	bkv_in_if.sink  rx,
	bkv_out_if.source res
);

	// input stage
	logic          valid_s1;
	logic          op_s1;
	logic [7:0]    byte_s1;

	// output stage
	logic          valid_s2;
	frame_result_t result_s2;

	// frame state
	frame_state_t  frame_q;
	frame_state_t  frame_nxt;
	logic          emit;
	frame_result_t result;
	logic          s1_go;

	bkv_step #(
		.FRAME_BYTES(FRAME_BYTES),
		.KEY_BYTES  (KEY_BYTES)
	) u_step (
		.cur    (frame_q),
		.op     (op_s1),
		.rx_byte(byte_s1),
		.nxt    (frame_nxt),
		.emit   (emit),
		.result (result)
	);

	// the stage-1 item retires unless it has a result and the output is held
	assign s1_go    = valid_s1 && (!emit || !valid_s2 || res.ready);
	assign rx.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			op_s1   <= rx.op;
			byte_s1 <= rx.rx_byte;
		end
	end

	// frame state commits when the stage-1 item retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (s1_go) begin
			frame_q <= frame_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go && emit) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			result_s2 <= result;
		end
	end

	assign res.valid     = valid_s2;
	assign res.status    = result_s2.status;
	assign res.key_class = result_s2.key_class;
	assign res.key_len   = result_s2.key_len;
	assign res.number    = result_s2.number;

	// a result always closes the frame
	a_emit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && emit |=> !frame_q.in_frame)
		else $error("frame still open after result");

	// closed frame carries no leftover state
	a_closed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_q.in_frame |-> frame_q.stored_count == '0 && !frame_q.comma_seen)
		else $error("stale state outside a frame");

	// stored count never passes the frame limit
	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q.stored_count <= CNT_W'(FRAME_BYTES - 1))
		else $error("stored count beyond frame limit");

	// an ok result always names an odometer key
	a_ok_class: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.status == ST_OK |-> result_s2.key_class != KC_OTHER)
		else $error("ok status with other key class");

endmodule

// ===== bench/bracket_key_value_frame_parser_core_tb.sv =====
`timescale 1ns / 100ps

module bracket_key_value_frame_parser_core_tb;
	import bkv_pkg::*;

	localparam int unsigned FRAME_MAX = FRAME_BYTES_DEF;
	localparam int unsigned KEY_MAX   = KEY_BYTES_DEF;
	localparam int unsigned CNT_SAT   = 63;

	typedef struct packed {
		logic       op;
		logic [7:0] b;
	} rx_item_t;

	// Frame shapes for the random part. Numeric odometer frames dominate so
	// that most traffic reaches the value parser.
	typedef enum {
		FK_NUM, FK_EMPTY_VAL, FK_BAD_CHAR, FK_OTHER_KEY, FK_EMPTY_KEY,
		FK_NO_COMMA, FK_LONG, FK_NOISE, FK_LINE_ERR, FK_RESTART
	} frame_kind_t;

	// Tracks the parser state per accepted transfer and holds the results
	// that the closing brackets seen so far must produce.
	class frame_result_board;
		logic                in_frame;
		logic [CNT_W-1:0]    stored_cnt;
		logic                comma_seen;
		logic [CNT_W-1:0]    key_cnt;
		logic [MATCH_W-1:0]  odo_prog;
		logic [MATCH_W-1:0]  q4_prog;
		logic [NUM_W-1:0]    acc;
		logic [CNT_W-1:0]    digit_cnt;
		logic                value_bad;
		frame_result_t       pending[$];
		int unsigned         errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			in_frame   = 1'b0;
			stored_cnt = '0;
			comma_seen = 1'b0;
			key_cnt    = '0;
			odo_prog   = '0;
			q4_prog    = '0;
			acc        = '0;
			digit_cnt  = '0;
			value_bad  = 1'b0;
		endfunction

		function logic [MATCH_W-1:0] step_match(logic [MATCH_W-1:0] prog, string key,
			logic [7:0] b);
			if (prog >= key.len() || key[prog] != b) begin
				return MATCH_FAIL;
			end
			return prog + 1'b1;
		endfunction

		function void key_byte(logic [7:0] b);
			if (key_cnt < CNT_SAT) begin
				key_cnt++;
			end
			odo_prog = step_match(odo_prog, "odo", b);
			q4_prog  = step_match(q4_prog, "q4_odo", b);
		endfunction

		function void value_byte(logic [7:0] b);
			logic [NUM_W-1:0] d;
			logic [NUM_W-1:0] lim;
			if (digit_cnt < CNT_SAT) begin
				digit_cnt++;
			end
			if (value_bad) begin
				return;
			end
			if (b < CH_ZERO || b > CH_NINE) begin
				value_bad = 1'b1;
				return;
			end
			d   = NUM_W'(b - CH_ZERO);
			lim = ({NUM_W{1'b1}} - d) / 10;
			if (acc > lim) begin
				value_bad = 1'b1;
			end else begin
				acc = acc * 10 + d;
			end
		endfunction

		function void close_frame();
			frame_result_t r;
			r = '0;
			if (!comma_seen) begin
				r.status = ST_FORMAT;
			end else begin
				r.key_len = key_cnt;
				if (key_cnt == 0 || key_cnt >= KEY_MAX) begin
					r.status = ST_KEY_ERR;
				end else begin
					if (odo_prog == ODO_LEN) begin
						r.key_class = KC_ODO;
					end else if (q4_prog == Q4ODO_LEN) begin
						r.key_class = KC_Q4ODO;
					end
					if (r.key_class == KC_OTHER) begin
						r.status = ST_OTHER_KEY;
					end else if (digit_cnt == 0 || value_bad) begin
						r.status = ST_RANGE_ERR;
					end else begin
						r.status = ST_OK;
						r.number = acc;
					end
				end
			end
			pending.push_back(r);
			clear();
		endfunction

		function void note_rx(logic op, logic [7:0] b);
			if (op == OP_LINE_ERR) begin
				clear();
				return;
			end
			if (b == CH_LBRACK) begin
				clear();
				in_frame = 1'b1;
			end
			if (!in_frame) begin
				return;
			end
			if (stored_cnt >= FRAME_MAX - 1) begin
				clear();
				return;
			end
			stored_cnt++;
			if (b == CH_RBRACK) begin
				close_frame();
			end else if (b != CH_LBRACK) begin
				if (!comma_seen) begin
					if (b == CH_COMMA) begin
						comma_seen = 1'b1;
					end else begin
						key_byte(b);
					end
				end else begin
					value_byte(b);
				end
			end
		endfunction

		function void check_res(frame_result_t got);
			frame_result_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result: status %0d key_class %0d key_len %0d number %0d",
					got.status, got.key_class, got.key_len, got.number);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, got.status);
				errors++;
			end
			if (got.key_class !== exp.key_class) begin
				$error("key_class: expected %0d, actual %0d", exp.key_class, got.key_class);
				errors++;
			end
			if (got.key_len !== exp.key_len) begin
				$error("key_len: expected %0d, actual %0d", exp.key_len, got.key_len);
				errors++;
			end
			if (got.number !== exp.number) begin
				$error("number: expected %0d, actual %0d", exp.number, got.number);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bkv_in_if  rx_if ();
	bkv_out_if res_if ();

	bracket_key_value_frame_parser_core #(
		.FRAME_BYTES(FRAME_MAX),
		.KEY_BYTES  (KEY_MAX)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_if.sink),
		.res   (res_if.source)
	);

	frame_result_board board = new();

	rx_item_t    rx_items[$];
	int unsigned rx_gap_pct      = 0;   // sender idles this share of cycles
	int unsigned res_stall_pct   = 0;   // receiver stalls this share of cycles
	int unsigned res_hold_cycles = 0;   // long hold-off, counted down at negedge

	frame_kind_t kind_pool[16] = '{
		FK_NUM, FK_NUM, FK_NUM, FK_NUM, FK_NUM, FK_NUM,
		FK_EMPTY_VAL, FK_BAD_CHAR, FK_OTHER_KEY, FK_OTHER_KEY, FK_EMPTY_KEY,
		FK_NO_COMMA, FK_LONG, FK_NOISE, FK_LINE_ERR, FK_RESTART
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Safety net against a hung handshake.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Stimulus building: everything goes into rx_items, then send_all
	// plays it out under the current idle setting.
	// ---------------------------------------------------------------
	task automatic add_byte(logic [7:0] b);
		rx_items.push_back('{op: OP_BYTE, b: b});
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			add_byte(s[i]);
		end
	endtask

	// rx_byte is don't-care on a line error; randomize it anyway
	task automatic add_line_err();
		rx_items.push_back('{op: OP_LINE_ERR, b: 8'($urandom_range(0, 255))});
	endtask

	// any byte that is neither a bracket nor a comma
	function automatic logic [7:0] plain_char();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == CH_LBRACK || b == CH_RBRACK || b == CH_COMMA);
		return b;
	endfunction

	// a non-digit that keeps the frame open; commas included
	function automatic logic [7:0] non_digit();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == CH_LBRACK || b == CH_RBRACK || (b >= CH_ZERO && b <= CH_NINE));
		return b;
	endfunction

	function automatic string odo_key();
		return ($urandom_range(0, 1) == 0) ? "odo" : "q4_odo";
	endfunction

	function automatic string digits(int unsigned n);
		string s;
		s = "";
		for (int unsigned i = 0; i < n; i++) begin
			s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
		end
		return s;
	endfunction

	// Decimal value text: the 64-bit limit, one past it, zero, far too many
	// digits, or a random value spread over all magnitudes.
	function automatic string num_text();
		logic [63:0] v;
		string       s;
		case ($urandom_range(0, 9))
			0:       s = "18446744073709551615";
			1:       s = "18446744073709551616";
			2:       s = "0";
			3:       s = digits($urandom_range(21, 24));
			default: begin
				v = {$urandom(), $urandom()};
				v = v >> $urandom_range(0, 63);
				s = $sformatf("%0d", v);
			end
		endcase
		if ($urandom_range(0, 3) == 0) begin
			s = {"0", s};
		end
		return s;
	endfunction

	task automatic add_num_frame();
		add_text({"[", odo_key(), ",", num_text(), "]"});
	endtask

	task automatic add_random_frame();
		frame_kind_t kind;
		int unsigned n;
		kind = kind_pool[$urandom_range(0, 15)];
		case (kind)
			FK_NUM: add_num_frame();
			FK_EMPTY_VAL: add_text({"[", odo_key(), ",]"});
			FK_BAD_CHAR: begin
				add_text({"[", odo_key(), ",", digits($urandom_range(0, 4))});
				add_byte(non_digit());
				add_text({digits($urandom_range(0, 4)), "]"});
			end
			FK_OTHER_KEY: begin
				add_byte(CH_LBRACK);
				case ($urandom_range(0, 7))
					0:       add_text("od");
					1:       add_text("odoo");
					2:       add_text("q4_od");
					3:       add_text("q4_odoo");
					4:       add_text("Odo");
					default: begin
						n = $urandom_range(1, 20);
						repeat (n) add_byte(plain_char());
					end
				endcase
				add_byte(CH_COMMA);
				n = $urandom_range(0, 6);
				repeat (n) add_byte(non_digit());
				add_byte(CH_RBRACK);
			end
			FK_EMPTY_KEY: add_text({"[,", num_text(), "]"});
			FK_NO_COMMA: begin
				add_byte(CH_LBRACK);
				n = $urandom_range(0, 8);
				repeat (n) add_byte(plain_char());
				add_byte(CH_RBRACK);
			end
			FK_LONG: begin
				// body around the FRAME_MAX-1 cutoff, so some survive and
				// some are dropped on the byte that overflows
				n = $urandom_range(34, 42);
				if ($urandom_range(0, 1) == 0) begin
					add_text({"[odo,", digits(n - 4), "]"});
				end else begin
					add_byte(CH_LBRACK);
					repeat (n) add_byte(plain_char());
					add_byte(CH_RBRACK);
				end
			end
			FK_NOISE: begin
				n = $urandom_range(1, 4);
				repeat (n) begin
					if ($urandom_range(0, 3) == 0) begin
						add_line_err();
					end else begin
						add_byte(8'($urandom_range(0, 255)));
					end
				end
			end
			FK_LINE_ERR: begin
				add_text({"[", odo_key(), ",", digits($urandom_range(0, 5))});
				add_line_err();
				add_text({digits($urandom_range(0, 3)), "]"});
			end
			FK_RESTART: begin
				add_byte(CH_LBRACK);
				n = $urandom_range(0, 5);
				repeat (n) add_byte(plain_char());
				add_num_frame();
			end
			default: add_num_frame();
		endcase
	endtask

	task automatic build_items(int unsigned count);
		while (rx_items.size() < count) begin
			add_random_frame();
		end
	endtask

	// Drives each queued item at the falling edge and holds it until the
	// transfer happens at a rising edge. Returns right after the last
	// transfer, with valid still high.
	task automatic send_all();
		rx_item_t it;
		while (rx_items.size() != 0) begin
			it = rx_items.pop_front();
			@(negedge clk);
			while ($urandom_range(0, 99) < rx_gap_pct) begin
				rx_if.valid = 1'b0;
				@(negedge clk);
			end
			rx_if.valid   = 1'b1;
			rx_if.op      = it.op;
			rx_if.rx_byte = it.b;
			@(posedge clk);
			while (!rx_if.ready) begin
				@(posedge clk);
			end
			board.note_rx(it.op, it.b);
		end
	endtask

	// Result side: ready decided at negedge, transfer checked at posedge.
	initial begin
		frame_result_t got;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (res_hold_cycles != 0) begin
				res_if.ready = 1'b0;
				res_hold_cycles--;
			end else begin
				res_if.ready = ($urandom_range(0, 99) >= res_stall_pct);
			end
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				got.status    = res_if.status;
				got.key_class = res_if.key_class;
				got.key_len   = res_if.key_len;
				got.number    = res_if.number;
				board.check_res(got);
			end
		end
	end

	// Main sequence: reset, directed frames, four idle phases, then a long
	// receiver hold-off to back the block up into its input.
	initial begin
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.op      = OP_BYTE;
		rx_if.rx_byte = 8'h00;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: byte extremes outside a frame, a plain odometer frame,
		// missing comma, empty key, bracket restart into q4_odo with an
		// empty value, and a line error that kills the frame before ']'
		add_byte(8'h00);
		add_byte(8'hFF);
		add_text("[odo,7]");
		add_text("[]");
		add_text("[,1]");
		add_text("[x[q4_odo,]");
		add_text("[od");
		add_line_err();
		add_text("]");
		send_all();

		// idle phases; settings change right after a transfer edge, away
		// from the negedge where the receiver reads them
		for (int p = 0; p < 4; p++) begin
			case (p)
				0:       begin rx_gap_pct = 0;  res_stall_pct = 0;  end
				1:       begin rx_gap_pct = 50; res_stall_pct = 0;  end
				2:       begin rx_gap_pct = 0;  res_stall_pct = 50; end
				default: begin rx_gap_pct = 29; res_stall_pct = 29; end
			endcase
			build_items(200);
			send_all();
		end

		// long hold-off on the result side while the sender keeps pushing
		rx_gap_pct      = 0;
		res_stall_pct   = 0;
		res_hold_cycles = 400;
		build_items(150);
		send_all();

		@(negedge clk);
		rx_if.valid = 1'b0;
		while (board.pending.size() != 0) begin
			@(posedge clk);
		end
		// catch any stray result after the last expected one
		repeat (8) @(posedge clk);

		if (board.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bkv_pkg.sv
design/bkv_in_if.sv
design/bkv_out_if.sv
design/bkv_step.sv
design/bracket_key_value_frame_parser_core.sv
bench/bracket_key_value_frame_parser_core_tb.sv
